[design/gtg_pkg.sv]
// Package: shared types, constants and the arctangent table for the go-to-goal controller.
`timescale 1ns / 1ps
package gtg_pkg;

    localparam int CordicStepsDefault = 16;

    localparam logic signed [34:0] AngHalfPi = 35'sd1686629713;
    localparam logic [16:0]        LinLimit  = 17'd65536;
    localparam logic [16:0]        LinFallbk = 17'd32768;
    localparam logic signed [21:0] TurnCap   = 22'sd32768;
    localparam logic signed [21:0] TurnFloor = -22'sd1647100;

    localparam logic [31:0] GoalReset = 32'd262144;
    localparam logic [30:0] TolReset  = 31'd32768;
    localparam logic [15:0] GainReset = 16'd19661;

    // Register indexes on the configuration port.
    localparam logic [1:0] RegGoalX = 2'd0;
    localparam logic [1:0] RegGoalY = 2'd1;
    localparam logic [1:0] RegTol   = 2'd2;
    localparam logic [1:0] RegGain  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_TOL,
        S_ROOT,
        S_GAIN,
        S_QSQ,
        S_QROOT,
        S_YAW,
        S_BEAR,
        S_TURN,
        S_OUT
    } t_state;

    // Arctangent table, Q2.30 radians, rounded to nearest.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd31: v = 30'd0;
            default: v = 30'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

[design/go_to_goal_velocity_controller.sv]
// Top level: go-to-goal proportional controller with a shared sequential datapath.
`timescale 1ns / 1ps
// Usage:
// - Slave stream (s_axis_*) takes one odometry word: pose_x, pose_y, quat_z.
// - Master stream (m_axis_*) returns one command word per odometry word:
//   linear_speed, turn_rate, goal_reached.
// - The APB port holds goal_x, goal_y, arrive_tolerance and linear_gain at
//   byte addresses 0, 4, 8 and 12; write them only while the block is idle.
// Timing:
// - A commanding word goes through squares and tolerance compare, two
//   square roots (distance and quaternion cosine) on one shared
//   add/compare unit, two CORDIC passes on one shared rotation unit, and
//   the gain, setup, turn and output steps.
//   The block returns to idle as the result loads, ready for the next word.
// - A word inside tolerance after the first command skips the roots and
//   CORDIC passes; once done latches, a word goes straight to output.
// - s_axis_tready is high only while idle. A waiting result does not block
//   the input: one more word is taken and computed, then held at the output
//   step until the result register is free.
// Reset:
// - Configuration registers, state and flags return to their reset values;
//   the first word after reset always gives a command; done latches until the next reset.
module go_to_goal_velocity_controller #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] pose_x, [63:32] pose_y, [79:64] quat_z
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] linear_speed, [38:17] turn_rate, [39] goal_reached
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [5:0] LastStep = 6'(Steps - 1);

    gtg_pkg::t_state r_state, n_state;

    logic signed [31:0] r_goal_x, r_goal_y;
    logic [30:0] r_tol;
    logic [15:0] r_gain;
    logic        r_cmd, r_done;

    logic signed [32:0] r_dx, r_dy;
    logic signed [15:0] r_q;
    logic [65:0] r_acc;       // sum of squares / square work
    logic [66:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_cnt;
    logic        tol_hit;
    logic [16:0] r_lin;
    logic signed [21:0] r_turn;
    logic        r_hit;
    logic signed [35:0] r_cx, r_cy;
    logic signed [34:0] r_z;
    logic signed [35:0] r_yaw;
    logic        r_ov;       // result waiting
    logic [39:0] r_out;
    logic [31:0] r_mul_a;     // multiply operand register

    // APB write and read
    logic wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= gtg_pkg::GoalReset;
            r_goal_y <= gtg_pkg::GoalReset;
            r_tol    <= gtg_pkg::TolReset;
            r_gain   <= gtg_pkg::GainReset;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                gtg_pkg::RegGoalX: r_goal_x <= pwdata;
                gtg_pkg::RegGoalY: r_goal_y <= pwdata;
                gtg_pkg::RegTol:   r_tol    <= pwdata[30:0];
                gtg_pkg::RegGain:  r_gain   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gtg_pkg::RegGoalX: prdata = r_goal_x;
            gtg_pkg::RegGoalY: prdata = r_goal_y;
            gtg_pkg::RegTol:   prdata = {1'b0, r_tol};
            gtg_pkg::RegGain:  prdata = {16'd0, r_gain};
            default:           prdata = 32'd0;
        endcase
    end

    // Shared square root step: one result bit per cycle
    logic [66:0] sq_rem;
    logic [34:0] sq_trial;
    logic        sq_take;
    always_comb begin
        sq_rem   = {r_rem[64:0], r_acc[65:64]};
        sq_trial = {r_root, 2'b01};
        sq_take  = sq_rem >= {32'd0, sq_trial};
    end

    // Shared CORDIC rotation step
    logic signed [35:0] xs, ys;
    logic signed [34:0] tab;
    logic               y_pos;
    always_comb begin
        xs    = r_cx >>> r_cnt[4:0];
        ys    = r_cy >>> r_cnt[4:0];
        tab   = {5'd0, gtg_pkg::atan_q30(r_cnt[4:0])};
        y_pos = r_cy > 36'sd0;
    end

    // Pre-rotation of a CORDIC operand into the right half plane
    function automatic logic [106:0] prerot(input logic signed [35:0] y,
                                            input logic signed [35:0] x);
        logic signed [35:0] nx, ny;
        logic signed [34:0] nz;
        nx = x; ny = y; nz = '0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; nz = gtg_pkg::AngHalfPi;
            end else begin
                nx = -y; ny = x; nz = -gtg_pkg::AngHalfPi;
            end
        end
        return {nx, ny, nz};
    endfunction

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtg_pkg::S_IDLE:  if (s_axis_tvalid) n_state =
                                  r_done ? gtg_pkg::S_OUT : gtg_pkg::S_SQX;
            gtg_pkg::S_SQX:   n_state = gtg_pkg::S_SQY;
            gtg_pkg::S_SQY:   n_state = gtg_pkg::S_TOL;
            gtg_pkg::S_TOL:   n_state = (r_cmd && tol_hit) ? gtg_pkg::S_OUT
                                                           : gtg_pkg::S_ROOT;
            gtg_pkg::S_ROOT:  if (r_cnt == 6'd32) n_state = gtg_pkg::S_GAIN;
            gtg_pkg::S_GAIN:  n_state = gtg_pkg::S_QSQ;
            gtg_pkg::S_QSQ:   n_state = gtg_pkg::S_QROOT;
            gtg_pkg::S_QROOT: if (r_cnt == 6'd32) n_state = gtg_pkg::S_YAW;
            gtg_pkg::S_YAW:   if (r_cnt == LastStep) n_state = gtg_pkg::S_BEAR;
            gtg_pkg::S_BEAR:  if (r_cnt == LastStep) n_state = gtg_pkg::S_TURN;
            gtg_pkg::S_TURN:  n_state = gtg_pkg::S_OUT;
            gtg_pkg::S_OUT:   if (!r_ov || m_axis_tready) n_state = gtg_pkg::S_IDLE;
            default:          n_state = gtg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gtg_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Output side
    assign s_axis_tready = (r_state == gtg_pkg::S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // Datapath, driven by the state
    logic [106:0] pr;
    logic signed [35:0] qx_in, turn_w;
    logic signed [37:0] diff;
    logic [32:0] adx, ady;
    logic [48:0] gprod;
    logic [31:0] qq;
    always_comb begin
        adx   = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        ady   = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
        tol_hit = r_acc <= 66'(r_tol * r_tol);
        gprod = 49'(r_gain) * 49'(r_root);
        qq    = 32'(signed'(r_q) * signed'(r_q));
        qx_in = 36'({3'd0, r_root});
        pr    = (r_state == gtg_pkg::S_QROOT)
              ? prerot(36'(signed'({r_q, 16'd0})), qx_in)
              : prerot(36'(r_dy), 36'(r_dx));
        // bearing is zero exactly at the goal
        diff  = ((r_dx == 0 && r_dy == 0) ? 38'sd0 : 38'(r_z)) - 38'(r_yaw);
        turn_w = 36'((diff * 4 + 38'sd8192) >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= 1'b0;
            r_done <= 1'b0;
            r_ov   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Load the result register when it is free, drop it once taken
            if (r_state == gtg_pkg::S_OUT && (!r_ov || m_axis_tready)) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                gtg_pkg::S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_dx <= 33'(r_goal_x) - 33'(signed'(s_axis_tdata[31:0]));
                        r_dy <= 33'(r_goal_y) - 33'(signed'(s_axis_tdata[63:32]));
                        if (signed'(s_axis_tdata[79:64]) > 16'sd16384)
                            r_q <= 16'sd16384;
                        else if (signed'(s_axis_tdata[79:64]) < -16'sd16384)
                            r_q <= -16'sd16384;
                        else
                            r_q <= s_axis_tdata[79:64];
                        r_lin  <= '0;
                        r_turn <= '0;
                        r_hit  <= 1'b1;
                    end
                end
                gtg_pkg::S_SQX: r_acc <= 66'(adx * adx);
                gtg_pkg::S_SQY: r_acc <= r_acc + 66'(ady * ady);
                gtg_pkg::S_TOL: begin
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                    if (r_cmd && tol_hit) r_done <= 1'b1;
                end
                gtg_pkg::S_ROOT, gtg_pkg::S_QROOT: begin
                    r_rem  <= sq_take ? sq_rem - {32'd0, sq_trial} : sq_rem;
                    r_root <= {r_root[31:0], sq_take};
                    r_acc  <= {r_acc[63:0], 2'b00};
                    r_cnt  <= (r_cnt == 6'd32) ? 6'd0 : r_cnt + 6'd1;
                    if (r_cnt == 6'd32 && r_state == gtg_pkg::S_QROOT) begin
                        {r_cx, r_cy, r_z} <= prerot(36'(signed'({r_q, 16'd0})),
                            36'({3'd0, r_root[31:0], sq_take}));
                    end
                end
                gtg_pkg::S_GAIN: begin
                    r_lin <= (gprod[48:16] > 33'(gtg_pkg::LinLimit))
                           ? gtg_pkg::LinFallbk : gprod[32:16];
                    r_mul_a <= qq;
                end
                gtg_pkg::S_QSQ: begin
                    r_acc  <= {2'b00, 64'h1000_0000_0000_0000 - {r_mul_a, 32'd0}};
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end
                gtg_pkg::S_YAW, gtg_pkg::S_BEAR: begin
                    r_cnt <= (r_cnt == LastStep) ? 6'd0 : r_cnt + 6'd1;
                    if (r_cnt == LastStep && r_state == gtg_pkg::S_YAW) begin
                        r_yaw <= 36'(y_pos ? r_z + tab : r_z - tab) * 2;
                        {r_cx, r_cy, r_z} <= (r_dx == 0 && r_dy == 0)
                            ? {36'sd1, 36'sd0, 35'sd0} : pr;
                    end else if (y_pos) begin
                        r_cx <= r_cx + ys; r_cy <= r_cy - xs; r_z <= r_z + tab;
                    end else begin
                        r_cx <= r_cx - ys; r_cy <= r_cy + xs; r_z <= r_z - tab;
                    end
                end
                gtg_pkg::S_TURN: begin
                    r_cmd <= 1'b1;
                    r_hit <= 1'b0;
                    if (turn_w > 36'(gtg_pkg::TurnCap))
                        r_turn <= gtg_pkg::TurnCap;
                    else if (turn_w < 36'(gtg_pkg::TurnFloor))
                        r_turn <= gtg_pkg::TurnFloor;
                    else
                        r_turn <= turn_w[21:0];
                end
                gtg_pkg::S_OUT: begin
                    if (!r_ov || m_axis_tready) r_out <= {r_hit, r_turn, r_lin};
                end
                default: ;
            endcase
        end
    end

    // Checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gtg_pkg::S_IDLE) |-> !s_axis_tready) else $error("busy accept");
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[39]) |-> (m_axis_tdata[38:0] == 39'd0))
        else $error("done with command");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done) else $error("done dropped");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

[verif/go_to_goal_velocity_controller_test.sv]
// Testbench: checks the go-to-goal controller against a predictor of its commands.
`timescale 1ns / 1ps
module go_to_goal_velocity_controller_test;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 200;
    localparam int  HOLD_OFF    = 500;
    localparam int  STEPS       = gtg_pkg::CordicStepsDefault;
    localparam longint HALF_PI  = 64'sd1686629713;

    typedef struct packed {
        logic [16:0]        speed;
        logic signed [21:0] turn;
        logic               reached;
    } t_command;

    // Scoreboard: models the controller and holds commands not yet seen.
    class command_scoreboard;
        longint   goal_x, goal_y, tol, gain;
        bit       issued, latched;
        int       errs;
        t_command pending[$];
        longint   atan_tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
            32, 16, 8, 4, 2, 1, 0};

        function new();
            goal_x = 262144; goal_y = 262144; tol = 32768; gain = 19661;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                gtg_pkg::RegGoalX: goal_x = longint'(signed'(v));
                gtg_pkg::RegGoalY: goal_y = longint'(signed'(v));
                gtg_pkg::RegTol:   tol    = longint'(v[30:0]);
                gtg_pkg::RegGain:  gain   = longint'(v[15:0]);
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errs++;
        endtask

        // Floor square root of a 68-bit value.
        function longint root68(logic [67:0] v);
            logic [71:0] rem, root, trial;
            rem = 0; root = 0;
            for (int p = 33; p >= 0; p--) begin
                rem   = (rem << 2) | 72'(v[2*p +: 2]);
                root  = root << 1;
                trial = (root << 1) | 72'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = root | 72'd1;
                end
            end
            return longint'(root);
        endfunction

        // Vectoring CORDIC, angle in Q2.30 radians.
        function longint angle_of(longint y, longint x);
            longint z, t, xs, ys;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin x = y;  y = -t; z = HALF_PI;  end
                else        begin x = -y; y = t;  z = -HALF_PI; end
            end
            for (int i = 0; i < (STEPS > 32 ? 32 : STEPS); i++) begin
                xs = x >>> i; ys = y >>> i;
                if (y > 0) begin x = x + ys; y = y - xs; z = z + atan_tab[i]; end
                else       begin x = x - ys; y = y + xs; z = z - atan_tab[i]; end
            end
            return z;
        endfunction

        function logic [67:0] dist_sq(longint px, longint py);
            longint ax, ay;
            ax = goal_x - px; ay = goal_y - py;
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            return 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
        endfunction

        function bit inside_tol(longint px, longint py);
            return dist_sq(px, py) <= 68'(tol) * 68'(tol);
        endfunction

        // Note one accepted odometry word and queue the command it gives.
        function void note_odometry(logic [79:0] w);
            t_command c;
            longint px, py, q, cq, distance, lin, yaw, bearing, turn;
            px = longint'(signed'(w[31:0]));
            py = longint'(signed'(w[63:32]));
            q  = longint'(signed'(w[79:64]));
            c  = '0;
            if (latched || (issued && inside_tol(px, py))) begin
                latched   = 1;
                c.reached = 1;
                pending.push_back(c);
                return;
            end
            distance = root68(dist_sq(px, py));
            lin  = (gain * distance) >> 16;
            if (lin > 65536) lin = 32768;
            if (q > 16384)  q = 16384;
            if (q < -16384) q = -16384;
            q  = q * 65536;
            cq = root68(68'((64'sd1 <<< 60) - q * q));
            yaw     = 2 * angle_of(q, cq);
            bearing = angle_of(goal_y - py, goal_x - px);
            turn    = (4 * (bearing - yaw) + 8192) >>> 14;
            if (turn > 32768)    turn = 32768;
            if (turn < -1647100) turn = -1647100;
            issued  = 1;
            c.speed = lin[16:0];
            c.turn  = turn[21:0];
            pending.push_back(c);
        endfunction

        // Compare one accepted command word with the oldest expectation.
        task check_command(logic [39:0] w);
            t_command e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word %h", w));
                return;
            end
            e = pending.pop_front();
            if (w[16:0] !== e.speed)
                report($sformatf("linear_speed %0d, want %0d", w[16:0], e.speed));
            if (w[38:17] !== e.turn)
                report($sformatf("turn_rate %0d, want %0d", $signed(w[38:17]), e.turn));
            if (w[39] !== e.reached)
                report($sformatf("goal_reached %0b, want %0b", w[39], e.reached));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [79:0] s_data = '0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        s_ready, m_valid, pready;
    logic [39:0] m_data;
    logic [31:0] prdata;

    command_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;
    int cycles = 0;

    go_to_goal_velocity_controller uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Command side: take words, stall in bursts, hold off on request.
    initial begin
        @(posedge i_clk);
        m_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_valid && m_ready) sb.check_command(m_data);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_req = 0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                m_ready <= 1'b1;
            end
        end
    end

    task reg_write(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, v);
    endtask

    // Drain every expected command, then let the datapath settle.
    task drain;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one odometry word; valid stays high unless a gap follows.
    task send_odometry(logic [31:0] px, logic [31:0] py, logic [15:0] qz);
        s_valid <= 1'b1;
        s_data  <= {qz, py, px};
        do @(posedge i_clk); while (!s_ready);
        sb.note_odometry({qz, py, px});
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    function logic [15:0] rand_quat();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // Random pose, rerolled while it would end the run early by arriving.
    task send_random;
        logic [31:0] px, py;
        do begin
            if ($urandom_range(0, 9) < 6) begin
                px = $urandom; py = $urandom;
            end else begin
                px = 32'(sb.goal_x + $urandom_range(0, 1 << 20) - (1 << 19));
                py = 32'(sb.goal_y + $urandom_range(0, 1 << 20) - (1 << 19));
            end
        end while (sb.inside_tol(longint'(signed'(px)), longint'(signed'(py))));
        send_odometry(px, py, rand_quat());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First word sits exactly on the goal: still commands, bearing of zero.
        send_odometry(32'd262144, 32'd262144, 16'd0);
        drain();
        reg_write(gtg_pkg::RegTol, 32'd0);
        reg_write(gtg_pkg::RegGain, 32'h0000_FFFF);

        // Directed: pose and quaternion extremes, clamping, each quadrant.
        send_odometry(32'h8000_0000, 32'h8000_0000, 16'sd16384);
        send_odometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, -16'sd16384);
        send_odometry(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
        send_odometry(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
        send_odometry(32'h0008_0000, 32'd262144, 16'd0);
        send_odometry(32'h0008_0000, 32'h0008_0000, 16'd1);
        send_odometry(32'd0, 32'h0008_0000, 16'hFFFF);
        send_odometry(32'd262144, 32'h0008_0000, 16'sd11585);
        send_odometry(32'd262144, 32'd0, -16'sd11585);
        send_odometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd16383);
        send_odometry(32'd0, 32'd0, 16'hC000);
        drain();
        reg_write(gtg_pkg::RegGoalX, 32'h8000_0000);
        reg_write(gtg_pkg::RegGoalY, 32'h7FFF_FFFF);
        reg_write(gtg_pkg::RegGain, 32'd0);
        send_odometry(32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        send_odometry(32'h8000_0000, 32'h7FFF_FFFE, 16'sd16384);
        send_odometry(32'd0, 32'd0, 16'sd100);
        drain();
        reg_write(gtg_pkg::RegGoalX, 32'h7FFF_FFFF);
        reg_write(gtg_pkg::RegGoalY, 32'h8000_0000);
        reg_write(gtg_pkg::RegGain, 32'd1);
        send_odometry(32'h8000_0000, 32'h7FFF_FFFF, -16'sd100);
        send_odometry(32'h7FFF_FFFE, 32'h8000_0000, 16'd0);
        drain();

        // Random phases, each under a fresh setting.
        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph == 7);
            reg_write(gtg_pkg::RegGoalX,
                      ph < 2 ? 32'($urandom_range(0, 1 << 22) - (1 << 21)) : $urandom);
            reg_write(gtg_pkg::RegGoalY,
                      ph < 2 ? 32'($urandom_range(0, 1 << 22) - (1 << 21)) : $urandom);
            reg_write(gtg_pkg::RegTol, ph[0] ? 32'($urandom_range(0, 255)) : 32'd0);
            reg_write(gtg_pkg::RegGain, ph == 3 ? 32'h0000_FFFF : ph == 5 ? 32'd0
                                        : 32'($urandom_range(0, 65535)));
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 140; n++) begin
                send_random();
            end
            drain();
        end

        // Arrival: wide tolerance latches done; later words stay at zero.
        reg_write(gtg_pkg::RegTol, 32'h7FFF_FFFF);
        reg_write(gtg_pkg::RegGoalX, $urandom);
        for (int n = 0; n < 12; n++)
            send_odometry($urandom, $urandom, rand_quat());
        drain();

        if (sb.errs == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
design/gtg_pkg.sv
design/go_to_goal_velocity_controller.sv
verif/go_to_goal_velocity_controller_test.sv
